@@ sv/nbf_pkg.sv @@
`timescale 1ns / 1ps
// nbf_pkg: shared types and constants of the nibble bloom filter
// depends on nothing; imported by nbf_div, nibble_bloom_filter and the bench

package nbf_pkg;

	// field and cell widths
	localparam int HASH_W    = 64;
	localparam int CELL_W    = 4;
	localparam int CC_W      = 17;
	localparam int CFG_IDX_W = 8;
	localparam int OUT_W     = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SORT       = CFG_IDX_W'(1);

	// operation codes carried in tuser
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD2,
		ST_ADD3,
		ST_SORT,
		ST_DSTART,
		ST_DIV,
		ST_RD,
		ST_UPD,
		ST_DONE
	} state_t;

endpackage

@@ sv/nbf_ram.sv @@
`timescale 1ns / 1ps
// nbf_ram: generic single-port ram, one write or read a cycle, registered read
// depends on nothing

module nbf_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ sv/nbf_div.sv @@
`timescale 1ns / 1ps
// nbf_div: bit-serial remainder unit, one dividend bit a cycle
// depends on nbf_pkg (HASH_W)

module nbf_div
	import nbf_pkg::*;
#(
	parameter int MAX_CELLS = 65536
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [HASH_W-1:0]            dividend,
	input  logic [$clog2(MAX_CELLS+1)-1:0] modulus,
	output logic                         done,
	output logic [$clog2(MAX_CELLS)-1:0] remainder
);

	localparam int MW       = $clog2(MAX_CELLS + 1);
	localparam int AW       = $clog2(MAX_CELLS);
	localparam int CNT_W    = $clog2(HASH_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_W - 1);

	logic [HASH_W-1:0] quot_q;
	logic [MW-1:0]     rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [MW:0]   trial;
	logic [MW:0]   diff;
	logic          ge;
	logic [MW-1:0] rem_next;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, quot_q[HASH_W-1]};
		diff     = trial - {1'b0, modulus};
		ge       = (trial >= {1'b0, modulus});
		rem_next = ge ? diff[MW-1:0] : trial[MW-1:0];
	end

	// step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// dividend shifter and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[HASH_W-2:0], 1'b0};
			rem_q  <= rem_next;
		end
	end

	assign done      = done_q;
	// remainder is below the modulus, which the instantiating block keeps at or below MAX_CELLS
	assign remainder = rem_q[AW-1:0];

endmodule

@@ sv/nibble_bloom_filter.sv @@
`timescale 1ns / 1ps
// nibble_bloom_filter: bloom filter over a ram of 4-bit cells; uses nbf_pkg, nbf_div, nbf_ram
// sequencing: a new input word is taken only in idle, once all four positions of the last
// one are done and, for a query, once no older result word still waits; the
// query result word is offered as ready returns. each position takes a start, a remainder
// step per dividend bit, done, a ram read and a ram update. reset: asynchronous, then a sweep
// zeroes all MAX_CELLS cells with no input word taken; config writes are always taken

module nibble_bloom_filter
	import nbf_pkg::*;
#(
	parameter int MAX_CELLS = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CC_W-1:0]       cfg_data,
	// input words
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [2*HASH_W-1:0]   s_axis_tdata,   // first_hash [63:0], second_hash [127:64]
	input  logic [0:0]            s_axis_tuser,   // op [0]
	// result words
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata    // present [0], zero fill above
);

	localparam int AW = $clog2(MAX_CELLS);
	localparam int MW = $clog2(MAX_CELLS + 1);
	localparam int CW = (MW > CC_W) ? MW : CC_W;
	localparam logic [AW-1:0] CLR_LAST  = AW'(MAX_CELLS - 1);
	localparam logic [2:0]    SORT_LAST = 3'd4;
	localparam logic [1:0]    POS_LAST  = 2'd3;

	state_t state_q, state_d;

	logic [CC_W-1:0]   cell_count_q;
	logic              sort_q;
	logic [MW-1:0]     mod_q;
	logic [MW-1:0]     mod_eff;
	logic [HASH_W-1:0] v_q [4];
	logic              op_q;
	logic [2:0]        sort_step_q;
	logic [1:0]        pidx_q;
	logic              hit_q;
	logic [AW-1:0]     clr_q;
	logic              out_valid_q;
	logic              present_q;

	logic [HASH_W-1:0] cmp_a, cmp_b;
	logic              swap;
	logic              out_load;

	logic              div_start;
	logic              div_done;
	logic [AW-1:0]     div_rem;

	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [CELL_W-1:0] ram_wdata;
	logic [CELL_W-1:0] ram_rdata;
	logic [CELL_W-1:0] bit_mask;

	// effective modulus: zero acts as one, above capacity acts as capacity
	always_comb begin
		logic [CW-1:0] cc_ext;
		logic [CW-1:0] m;
		cc_ext = CW'(cell_count_q);
		if (cc_ext == '0) begin
			m = CW'(1);
		end else if (cc_ext > CW'(MAX_CELLS)) begin
			m = CW'(MAX_CELLS);
		end else begin
			m = cc_ext;
		end
		mod_eff = m[MW-1:0];
	end

	// shared comparator of the sorting network
	always_comb begin
		case (sort_step_q)
			3'd0: begin cmp_a = v_q[0]; cmp_b = v_q[1]; end
			3'd1: begin cmp_a = v_q[2]; cmp_b = v_q[3]; end
			3'd2: begin cmp_a = v_q[0]; cmp_b = v_q[2]; end
			3'd3: begin cmp_a = v_q[1]; cmp_b = v_q[3]; end
			default: begin cmp_a = v_q[1]; cmp_b = v_q[2]; end
		endcase
		swap = (cmp_a > cmp_b);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_q == CLR_LAST) state_d = ST_IDLE;
			ST_IDLE:   if (s_axis_tvalid) state_d = ST_ADD2;
			ST_ADD2:   state_d = ST_ADD3;
			ST_ADD3:   state_d = sort_q ? ST_SORT : ST_DSTART;
			ST_SORT:   if (sort_step_q == SORT_LAST) state_d = ST_DSTART;
			ST_DSTART: state_d = ST_DIV;
			ST_DIV:    if (div_done) state_d = ST_RD;
			ST_RD:     state_d = ST_UPD;
			ST_UPD: begin
				if (pidx_q != POS_LAST) begin
					state_d = ST_DSTART;
				end else if (op_q == OP_QUERY) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DONE:   if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		bit_mask      = CELL_W'(1) << pidx_q;
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		ram_we        = 1'b0;
		ram_addr      = div_rem;
		ram_wdata     = ram_rdata | bit_mask;
		out_load      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE:   s_axis_tready = 1'b1;
			ST_DSTART: div_start = 1'b1;
			ST_UPD:    ram_we = (op_q == OP_INSERT);
			ST_DONE:   out_load = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	// state, clearing sweep, sequencing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			sort_step_q <= '0;
			pidx_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == ST_IDLE) begin
				sort_step_q <= '0;
				pidx_q      <= '0;
			end
			if (state_q == ST_SORT) begin
				sort_step_q <= sort_step_q + 3'd1;
			end
			if (state_q == ST_UPD) begin
				pidx_q <= pidx_q + 2'd1;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q <= CC_W'(65536);
			sort_q       <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CELL_COUNT: cell_count_q <= cfg_data;
				REG_SORT:       sort_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// hash values: capture, derive, sort, rotate into the remainder unit; accumulate the hit
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				v_q[0] <= s_axis_tdata[HASH_W-1:0];
				v_q[1] <= s_axis_tdata[2*HASH_W-1:HASH_W];
				op_q   <= s_axis_tuser[0];
				mod_q  <= mod_eff;
				hit_q  <= 1'b1;
			end
			ST_ADD2: v_q[2] <= v_q[0] + v_q[1];
			ST_ADD3: v_q[3] <= v_q[2] + v_q[1];
			ST_SORT: begin
				if (swap) begin
					case (sort_step_q)
						3'd0: begin v_q[0] <= cmp_b; v_q[1] <= cmp_a; end
						3'd1: begin v_q[2] <= cmp_b; v_q[3] <= cmp_a; end
						3'd2: begin v_q[0] <= cmp_b; v_q[2] <= cmp_a; end
						3'd3: begin v_q[1] <= cmp_b; v_q[3] <= cmp_a; end
						default: begin v_q[1] <= cmp_b; v_q[2] <= cmp_a; end
					endcase
				end
			end
			ST_DSTART: begin
				v_q[0] <= v_q[1];
				v_q[1] <= v_q[2];
				v_q[2] <= v_q[3];
				v_q[3] <= v_q[0];
			end
			ST_UPD: hit_q <= hit_q & ram_rdata[pidx_q];
			default: ;
		endcase
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			present_q <= hit_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W-1){1'b0}}, present_q};

	// shared remainder unit
	nbf_div #(
		.MAX_CELLS (MAX_CELLS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (v_q[0]),
		.modulus   (mod_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	// cell store
	nbf_ram #(
		.WIDTH (CELL_W),
		.DEPTH (MAX_CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

@@ dv/tb_nibble_bloom_filter.sv @@
`timescale 1ns / 1ps
// tb_nibble_bloom_filter: self-checking bench for the nibble bloom filter, inserting and
// querying keys under several cell counts and sort settings and predicting every answer
// depends on nbf_pkg and nibble_bloom_filter with its submodules

module tb_nibble_bloom_filter
	import nbf_pkg::*;
();

	localparam int CELLS     = 65536;
	localparam int SETTLE    = 320;
	localparam int LIMIT_NS  = 25_000_000;
	localparam int PHASES    = 8;
	localparam int PER_PHASE = 167;
	localparam int POOL_MAX  = 64;
	localparam int REPORTS   = 10;

	typedef struct packed {
		logic              op;
		logic [HASH_W-1:0] first_hash;
		logic [HASH_W-1:0] second_hash;
	} key_word_t;

	// shadow copy of the cell ram and registers, plus the queue of query answers owed
	class bloom_board;
		bit [CELL_W-1:0] cells [CELLS];
		bit [CC_W-1:0]   cell_count;
		bit              sorted;
		bit              present_due [$];
		int              faults;
		int              results;

		function new();
			foreach (cells[i]) cells[i] = '0;
			cell_count = CC_W'(CELLS);
			sorted     = 1'b0;
			faults     = 0;
			results    = 0;
		endfunction

		function void fault(string msg);
			faults++;
			if (faults <= REPORTS)
				$display("%s", msg);
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] index, logic [CC_W-1:0] value);
			if (index == REG_CELL_COUNT)
				cell_count = value;
			else if (index == REG_SORT)
				sorted = value[0];
		endfunction

		function void order_pair(inout bit [HASH_W-1:0] lo, inout bit [HASH_W-1:0] hi);
			bit [HASH_W-1:0] t;
			if (lo > hi) begin
				t  = lo;
				lo = hi;
				hi = t;
			end
		endfunction

		// four double-hash positions, optionally sorted, folded into the cell range
		function void cell_slots(logic [HASH_W-1:0] h1, logic [HASH_W-1:0] h2,
				output int unsigned slot [4]);
			bit [HASH_W-1:0] v [4];
			bit [HASH_W-1:0] modulus;
			if (cell_count == 0)
				modulus = HASH_W'(1);
			else if (cell_count > CELLS)
				modulus = HASH_W'(CELLS);
			else
				modulus = HASH_W'(cell_count);
			v[0] = h1;
			v[1] = h2;
			v[2] = h1 + h2;
			v[3] = v[2] + h2;
			if (sorted) begin
				order_pair(v[0], v[1]);
				order_pair(v[2], v[3]);
				order_pair(v[0], v[2]);
				order_pair(v[1], v[3]);
				order_pair(v[1], v[2]);
			end
			for (int i = 0; i < 4; i++)
				slot[i] = int'(v[i] % modulus);
		endfunction

		function void note_word(key_word_t w);
			int unsigned slot [4];
			bit hit;
			cell_slots(w.first_hash, w.second_hash, slot);
			hit = 1'b1;
			for (int i = 0; i < 4; i++) begin
				if (w.op == OP_INSERT)
					cells[slot[i]][i] = 1'b1;
				else if (!cells[slot[i]][i])
					hit = 1'b0;
			end
			if (w.op == OP_QUERY)
				present_due.push_back(hit);
		endfunction

		function void check_word(logic present);
			bit want;
			results++;
			if (present_due.size() == 0) begin
				fault($sformatf("result %0d: present=%b with no query outstanding",
					results, present));
				return;
			end
			want = present_due.pop_front();
			if (present !== want)
				fault($sformatf("result %0d: present expected %b, got %b",
					results, want, present));
		endfunction

		function int pending();
			return present_due.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CC_W-1:0]      cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [2*HASH_W-1:0]  s_axis_tdata;   // first_hash [63:0], second_hash [127:64]
	logic [0:0]           s_axis_tuser;   // op [0]
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_W-1:0]     m_axis_tdata;   // present [0], zero fill above

	bloom_board board;
	key_word_t  key_pool [$];
	bit         calm = 1'b0;

	nibble_bloom_filter #(
		.MAX_CELLS(CELLS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop
	initial begin
		#(LIMIT_NS);
		$display("tb_nibble_bloom_filter: done, errors");
		$finish;
	end

	// result side back-pressure: short stalls, now and then a long clear stretch
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 40) == 0) begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(40, 200)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_word(m_axis_tdata[0]);
	end

	// register write; valid is left high so back-to-back writes need no toggle
	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CC_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		board.set_register(index, value);
	endtask

	// input word, optionally after a gap taken either at once or once the block is ready
	task automatic send_word(input logic op, input logic [HASH_W-1:0] h1,
			input logic [HASH_W-1:0] h2);
		key_word_t w;
		int mode;
		w.op          = op;
		w.first_hash  = h1;
		w.second_hash = h2;
		mode = calm ? 0 : int'($urandom_range(0, 5));
		if (mode >= 4) begin
			s_axis_tvalid <= 1'b0;
			if (mode == 5) begin
				do @(posedge clk); while (!s_axis_tready);
			end
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {w.second_hash, w.first_hash};
		s_axis_tuser  <= w.op;
		do @(posedge clk); while (!s_axis_tready);
		board.note_word(w);
	endtask

	// let every answer come back and any trailing insert finish before reconfiguring
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [HASH_W-1:0] any_hash();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2: return {1'b1, {(HASH_W-1){1'b0}}};
			3: return HASH_W'($urandom_range(0, 255));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// mostly insert-then-query of remembered keys, the rest queries of unknown keys
	task automatic random_word();
		key_word_t k;
		int pick;
		pick = int'($urandom_range(0, 19));
		if (pick < 9 || key_pool.size() == 0) begin
			k.op          = OP_INSERT;
			k.first_hash  = any_hash();
			k.second_hash = any_hash();
			send_word(OP_INSERT, k.first_hash, k.second_hash);
			key_pool.push_back(k);
			if (key_pool.size() > POOL_MAX)
				void'(key_pool.pop_front());
		end else if (pick < 16) begin
			k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			send_word(OP_QUERY, k.first_hash, k.second_hash);
		end else begin
			send_word(OP_QUERY, any_hash(), any_hash());
		end
	endtask

	// main sequence
	initial begin
		logic [CC_W-1:0] cc;
		logic [CC_W-1:0] sort_word;
		bit              srt;
		board = new();
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// full size, unsorted; sort write carries junk above bit 0
		write_register(REG_CELL_COUNT, CC_W'(CELLS));
		write_register(REG_SORT, {{(CC_W-1){1'b1}}, 1'b0});
		cfg_valid <= 1'b0;
		send_word(OP_QUERY, '0, '0);
		send_word(OP_INSERT, '0, '0);
		send_word(OP_QUERY, '0, '0);
		send_word(OP_INSERT, '1, '1);
		send_word(OP_QUERY, '1, '1);
		send_word(OP_QUERY, '1, HASH_W'(1));
		send_word(OP_INSERT, '1, HASH_W'(1));
		send_word(OP_QUERY, HASH_W'(1), '1);

		// zero cell count folds everything onto cell 0; stray indexes are ignored
		drain();
		write_register(REG_CELL_COUNT, '0);
		write_register(REG_SORT, {{(CC_W-1){1'b0}}, 1'b1});
		write_register(CFG_IDX_W'(REG_SORT + 1), '1);
		write_register('1, '0);
		cfg_valid <= 1'b0;
		send_word(OP_QUERY, {$urandom, $urandom}, {$urandom, $urandom});
		send_word(OP_INSERT, {$urandom, $urandom}, '1);
		send_word(OP_QUERY, {$urandom, $urandom}, {$urandom, $urandom});

		// count above capacity clips to full size, sorted, wrapping sums
		drain();
		write_register(REG_CELL_COUNT, '1);
		write_register(REG_SORT, '1);
		cfg_valid <= 1'b0;
		send_word(OP_INSERT, HASH_W'(5), '1);
		send_word(OP_QUERY, HASH_W'(5), '1);
		send_word(OP_QUERY, '1, HASH_W'(5));
		send_word(OP_INSERT, {1'b1, {(HASH_W-1){1'b0}}}, {1'b1, {(HASH_W-1){1'b0}}});
		send_word(OP_QUERY, {1'b1, {(HASH_W-1){1'b0}}}, {1'b1, {(HASH_W-1){1'b0}}});

		// random phases, each under its own setting
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: begin cc = CC_W'(16); srt = 1'b1; end
				1: begin cc = CC_W'(3); srt = 1'b0; end
				2: begin
					cc  = CC_W'($urandom_range(1, 300));
					srt = 1'($urandom_range(0, 1));
				end
				3: begin cc = CC_W'(CELLS); srt = 1'b1; end
				4: begin
					cc  = CC_W'($urandom_range(0, (1 << CC_W) - 1));
					srt = 1'($urandom_range(0, 1));
				end
				5: begin cc = CC_W'(1); srt = 1'b1; end
				6: begin cc = CC_W'($urandom_range(1, 4000)); srt = 1'b0; end
				default: begin cc = CC_W'(CELLS - 1); srt = 1'($urandom_range(0, 1)); end
			endcase
			sort_word    = CC_W'($urandom);
			sort_word[0] = srt;
			write_register(CFG_IDX_W'($urandom_range(REG_SORT + 1, (1 << CFG_IDX_W) - 1)),
				CC_W'($urandom));
			write_register(REG_CELL_COUNT, cc);
			write_register(REG_SORT, sort_word);
			cfg_valid <= 1'b0;
			key_pool.delete();
			calm = (p == PHASES - 1);
			for (int n = 0; n < PER_PHASE; n++)
				random_word();
		end

		// wind down
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (board.faults == 0)
			$display("tb_nibble_bloom_filter: done, clean");
		else
			$display("tb_nibble_bloom_filter: done, errors");
		$finish;
	end

endmodule
